// ----- design/csft_pkg.sv -----
// Shared types and character codes for the comment-stripping field tokenizer.
`default_nettype none

package csft_pkg;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_BYTE   = 3'd0,
        KIND_FEND   = 3'd1,
        KIND_EQUALS = 3'd2,
        KIND_LINE   = 3'd3,
        KIND_EOI    = 3'd4,
        KIND_ERR    = 3'd5
    } t_kind;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUALS = 8'h3D;

    localparam int MAX_RES  = 4;
    localparam int RES_AW   = $clog2(MAX_RES);
    localparam int RES_CW   = RES_AW + 1;

    // Result group queue depth (power of two)
    localparam int Q_DEPTH  = 2;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CW     = Q_AW + 1;

    // One result; after marks a result emitted once the line counter advanced
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  fbyte;
        logic [15:0] count;
        logic        after;
    } t_res;

    // All results caused by one request
    typedef struct packed {
        t_res [MAX_RES-1:0] res;
        logic [RES_CW-1:0]  n;
        logic [31:0]        old_line;
    } t_group;

endpackage

`default_nettype wire

// ----- design/comment_strip_field_tokenizer_unit.sv -----
// Top level of the comment-stripping field tokenizer.
`default_nettype none

// The first result of a request passes the input register and the result queue
// before it is presented. Throughput: one request per cycle while each yields
// at most one result and the receiver is ready; the output port drains one
// result per cycle while i_out_ready is high, so a request with several results
// holds the output until all are taken, buffered by a 2-group result queue.
// Reset: synchronous active-low i_rst_n clears lexer state, input valid and the queue.
module comment_strip_field_tokenizer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_end_of_input,
    input  wire logic        i_read_error,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_field_byte,
    output logic [31:0]      o_line_number,
    output logic [15:0]      o_field_count,
    output logic             o_last
);
    import csft_pkg::*;

    // Input register: hold one request until the core can place its results
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_eof;
    logic       r_err;

    logic   room;
    logic   fire;
    t_group group;

    // Fire the core when a request waits and the result queue has a free slot
    assign fire       = r_in_valid && room;
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Payload needs no reset; load on every accepted request
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_byte_value;
            r_eof  <= i_end_of_input;
            r_err  <= i_read_error;
        end
    end

    csft_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_byte),
        .i_eof   (r_eof),
        .i_err   (r_err),
        .o_group (group)
    );

    // Drop requests that produce nothing (whitespace, comment text)
    csft_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (fire && (group.n != '0)),
        .i_group       (group),
        .o_room        (room),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_field_byte  (o_field_byte),
        .o_line_number (o_line_number),
        .o_field_count (o_field_count),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

// ----- design/csft_core.sv -----
// Lexer state and single-pass decode of one request into a result group.
`default_nettype none

module csft_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_eof,
    input  wire logic             i_err,
    output csft_pkg::t_group      o_group
);
    import csft_pkg::*;

    typedef struct packed {
        logic        in_block;
        logic        in_line;
        logic        pslash;
        logic        pstar;
        logic        in_field;
        logic        line_started;
        logic [31:0] lines;
        logic [15:0] fields;
        logic        fail;
    } t_lex_state;

    typedef struct packed {
        t_lex_state st;
        t_group     grp;
        logic       incd;
    } t_work;

    t_lex_state r_st;
    t_lex_state n_st;
    t_work      w;

    function automatic t_work emit(t_work wi, t_kind k, logic [7:0] b, logic [15:0] c);
        t_work wo;
        wo = wi;
        wo.grp.res[wi.grp.n[RES_AW-1:0]] = '{kind: k, fbyte: b, count: c, after: wi.incd};
        wo.grp.n = wi.grp.n + RES_CW'(1);
        return wo;
    endfunction

    function automatic t_work bump(t_work wi);
        t_work wo;
        wo = wi;
        if (wi.st.fields != '1) begin
            wo.st.fields = wi.st.fields + 16'd1;
        end
        return wo;
    endfunction

    function automatic t_work put_byte(t_work wi, logic [7:0] c);
        t_work wo;
        wo = wi;
        if (!wo.st.in_field) begin
            wo.st.in_field = 1'b1;
            wo = bump(wo);
        end
        wo = emit(wo, KIND_BYTE, c, 16'd0);
        return wo;
    endfunction

    function automatic t_work end_field(t_work wi);
        t_work wo;
        wo = wi;
        if (wo.st.in_field) begin
            wo.st.in_field = 1'b0;
            wo = emit(wo, KIND_FEND, 8'd0, 16'd0);
        end
        return wo;
    endfunction

    function automatic t_work finish_line(t_work wi);
        t_work wo;
        wo = wi;
        if (wo.st.pslash) begin
            wo.st.pslash = 1'b0;
            wo = put_byte(wo, CH_SLASH);
        end
        wo = end_field(wo);
        wo.st.in_line = 1'b0;
        wo.st.pstar   = 1'b0;
        if (wo.st.lines != '1) begin
            wo.st.lines = wo.st.lines + 32'd1;
            wo.incd     = 1'b1;
        end
        if (wo.st.fields != 16'd0) begin
            wo = emit(wo, KIND_LINE, 8'd0, wo.st.fields);
        end
        wo.st.fields       = 16'd0;
        wo.st.line_started = 1'b0;
        return wo;
    endfunction

    function automatic t_work ordinary(t_work wi, logic [7:0] c);
        t_work wo;
        wo = wi;
        if (c == CH_SPACE || c == CH_TAB || c == CH_FF || c == CH_VT || c == CH_CR) begin
            wo = end_field(wo);
        end else if (c == CH_EQUALS) begin
            wo = end_field(wo);
            wo = bump(wo);
            wo = emit(wo, KIND_EQUALS, 8'd0, 16'd0);
        end else if (c == CH_HASH) begin
            wo = end_field(wo);
            wo.st.in_line = 1'b1;
        end else if (c == CH_SLASH) begin
            wo.st.pslash = 1'b1;
        end else begin
            wo = put_byte(wo, c);
        end
        return wo;
    endfunction

    always_comb begin
        w              = '0;
        w.st           = r_st;
        w.grp.old_line = r_st.lines;
        if (r_st.fail || i_err) begin
            w.st.fail = 1'b1;
            w = emit(w, KIND_ERR, 8'd0, 16'd0);
        end else if (i_eof) begin
            if (r_st.line_started) begin
                w = finish_line(w);
            end
            w = emit(w, KIND_EOI, 8'd0, 16'd0);
        end else if (i_byte == CH_NUL) begin
            w.st.fail = 1'b1;
            w = emit(w, KIND_ERR, 8'd0, 16'd0);
        end else begin
            w.st.line_started = 1'b1;
            if (i_byte == CH_LF) begin
                w = finish_line(w);
            end else if (r_st.in_line) begin
                // drop comment text
            end else if (r_st.in_block) begin
                if (r_st.pstar && i_byte == CH_SLASH) begin
                    w.st.in_block = 1'b0;
                    w.st.pstar    = 1'b0;
                end else begin
                    w.st.pstar = (i_byte == CH_STAR);
                end
            end else if (r_st.pslash) begin
                w.st.pslash = 1'b0;
                if (i_byte == CH_SLASH) begin
                    w = end_field(w);
                    w.st.in_line = 1'b1;
                end else if (i_byte == CH_STAR) begin
                    w = end_field(w);
                    w.st.in_block = 1'b1;
                    w.st.pstar    = 1'b0;
                end else begin
                    w = put_byte(w, CH_SLASH);
                    w = ordinary(w, i_byte);
                end
            end else begin
                w = ordinary(w, i_byte);
            end
        end
    end

    assign o_group = w.grp;
    assign n_st    = i_fire ? w.st : r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

endmodule

`default_nettype wire

// ----- design/csft_queue.sv -----
// Result group queue that hands out one result per output request.
`default_nettype none

module csft_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire csft_pkg::t_group i_group,
    output logic                  o_room,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [2:0]            o_kind,
    output logic [7:0]            o_field_byte,
    output logic [31:0]           o_line_number,
    output logic [15:0]           o_field_count,
    output logic                  o_last
);
    import csft_pkg::*;

    t_group            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_head;
    logic [Q_AW-1:0]   r_tail;
    logic [Q_CW-1:0]   r_count;
    logic [RES_AW-1:0] r_pos;
    logic [Q_AW-1:0]   n_head;
    logic [Q_AW-1:0]   n_tail;
    logic [Q_CW-1:0]   n_count;
    logic [RES_AW-1:0] n_pos;

    t_group head;
    t_res   cur;
    logic   last;
    logic   take;
    logic   pop;

    assign head = r_mem[r_head];
    assign cur  = head.res[r_pos];
    assign last = ({1'b0, r_pos} + RES_CW'(1)) == head.n;

    assign o_out_valid   = (r_count != '0);
    assign o_room        = (r_count != Q_CW'(Q_DEPTH));
    assign take          = o_out_valid && i_out_ready;
    assign pop           = take && last;

    assign o_kind        = cur.kind;
    assign o_field_byte  = cur.fbyte;
    assign o_field_count = cur.count;
    assign o_line_number = head.old_line + {31'd0, cur.after};
    assign o_last        = last;

    always_comb begin
        n_head  = pop ? r_head + Q_AW'(1) : r_head;
        n_tail  = i_push ? r_tail + Q_AW'(1) : r_tail;
        n_count = r_count + Q_CW'(i_push) - Q_CW'(pop);
        if (pop) begin
            n_pos = '0;
        end else if (take) begin
            n_pos = r_pos + RES_AW'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_group;
        end
    end

endmodule

`default_nettype wire

// ----- sim/csft_checker.sv -----
// Checker for the tokenizer: watches both channels, predicts tokens and compares them.
`default_nettype none

module csft_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_end_of_input,
    input  wire logic        i_read_error,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [7:0]  i_field_byte,
    input  wire logic [31:0] i_line_number,
    input  wire logic [15:0] i_field_count,
    input  wire logic        i_last,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);
    import csft_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  fbyte;
        logic [31:0] line;
        logic [15:0] count;
        logic        last;
    } t_token;

    t_token tokens_due[$];
    t_token got_tok;
    t_token want_tok;

    // Lexer state of the prediction
    logic        in_block;
    logic        in_hash;
    logic        slash_held;
    logic        star_held;
    logic        in_fld;
    logic        line_open;
    logic [31:0] line_cnt;
    logic [15:0] fld_cnt;
    logic        failed;

    int fail_cnt    = 0;
    int checked_cnt = 0;
    int step_first;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR: token %0d field %s: got 0x%0h, want 0x%0h",
                 checked_cnt, what, got, want);
        fail_cnt++;
    endtask

    function automatic void emit_tok(input t_kind k, input logic [7:0] b,
                                     input logic [15:0] c);
        t_token t;
        t.kind  = k;
        t.fbyte = b;
        t.line  = line_cnt;
        t.count = c;
        t.last  = 1'b0;
        tokens_due.push_back(t);
    endfunction

    function automatic void count_field();
        if (fld_cnt != 16'hFFFF)
            fld_cnt++;
    endfunction

    function automatic void field_byte_out(input logic [7:0] b);
        if (!in_fld) begin
            in_fld = 1'b1;
            count_field();
        end
        emit_tok(KIND_BYTE, b, 16'd0);
    endfunction

    function automatic void close_field();
        if (in_fld) begin
            in_fld = 1'b0;
            emit_tok(KIND_FEND, 8'd0, 16'd0);
        end
    endfunction

    // Flush a held slash, close the field, advance the line count, report a non-empty line.
    function automatic void close_line();
        if (slash_held) begin
            slash_held = 1'b0;
            field_byte_out(CH_SLASH);
        end
        close_field();
        in_hash   = 1'b0;
        star_held = 1'b0;
        if (line_cnt != 32'hFFFF_FFFF)
            line_cnt++;
        if (fld_cnt != 16'd0)
            emit_tok(KIND_LINE, 8'd0, fld_cnt);
        fld_cnt   = 16'd0;
        line_open = 1'b0;
    endfunction

    function automatic void plain_char(input logic [7:0] c);
        if (c == CH_SPACE || c == CH_TAB || c == CH_FF || c == CH_VT || c == CH_CR) begin
            close_field();
        end else if (c == CH_EQUALS) begin
            close_field();
            count_field();
            emit_tok(KIND_EQUALS, 8'd0, 16'd0);
        end else if (c == CH_HASH) begin
            close_field();
            in_hash = 1'b1;
        end else if (c == CH_SLASH) begin
            slash_held = 1'b1;
        end else begin
            field_byte_out(c);
        end
    endfunction

    function automatic void predict_step(input logic [7:0] c, input logic eoi,
                                         input logic rerr);
        t_token t;
        step_first = tokens_due.size();
        if (failed || rerr) begin
            failed = 1'b1;
            emit_tok(KIND_ERR, 8'd0, 16'd0);
        end else if (eoi) begin
            if (line_open)
                close_line();
            emit_tok(KIND_EOI, 8'd0, 16'd0);
        end else if (c == CH_NUL) begin
            failed = 1'b1;
            emit_tok(KIND_ERR, 8'd0, 16'd0);
        end else begin
            line_open = 1'b1;
            if (c == CH_LF) begin
                close_line();
            end else if (in_hash) begin
                // drop comment text
            end else if (in_block) begin
                if (star_held && c == CH_SLASH) begin
                    in_block  = 1'b0;
                    star_held = 1'b0;
                end else begin
                    star_held = (c == CH_STAR);
                end
            end else if (slash_held) begin
                slash_held = 1'b0;
                if (c == CH_SLASH) begin
                    close_field();
                    in_hash = 1'b1;
                end else if (c == CH_STAR) begin
                    close_field();
                    in_block  = 1'b1;
                    star_held = 1'b0;
                end else begin
                    field_byte_out(CH_SLASH);
                    plain_char(c);
                end
            end else begin
                plain_char(c);
            end
        end
        if (tokens_due.size() > step_first) begin
            t = tokens_due[tokens_due.size()-1];
            t.last = 1'b1;
            tokens_due[tokens_due.size()-1] = t;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_block   = 1'b0;
            in_hash    = 1'b0;
            slash_held = 1'b0;
            star_held  = 1'b0;
            in_fld     = 1'b0;
            line_open  = 1'b0;
            line_cnt   = 32'd0;
            fld_cnt    = 16'd0;
            failed     = 1'b0;
            tokens_due.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                predict_step(i_byte_value, i_end_of_input, i_read_error);
            if (i_out_valid && i_out_ready) begin
                if (tokens_due.size() == 0) begin
                    report_mismatch("unexpected", {29'd0, i_kind}, 32'd0);
                end else begin
                    want_tok       = tokens_due.pop_front();
                    got_tok.kind   = t_kind'(i_kind);
                    got_tok.fbyte  = i_field_byte;
                    got_tok.line   = i_line_number;
                    got_tok.count  = i_field_count;
                    got_tok.last   = i_last;
                    if (got_tok.kind !== want_tok.kind)
                        report_mismatch("kind", {29'd0, i_kind}, {29'd0, want_tok.kind});
                    if (got_tok.fbyte !== want_tok.fbyte)
                        report_mismatch("field_byte", {24'd0, i_field_byte},
                                        {24'd0, want_tok.fbyte});
                    if (got_tok.line !== want_tok.line)
                        report_mismatch("line_number", i_line_number, want_tok.line);
                    if (got_tok.count !== want_tok.count)
                        report_mismatch("field_count", {16'd0, i_field_count},
                                        {16'd0, want_tok.count});
                    if (got_tok.last !== want_tok.last)
                        report_mismatch("last", {31'd0, i_last}, {31'd0, want_tok.last});
                    checked_cnt++;
                end
            end
        end
        o_fail_count = fail_cnt;
        o_pending    = tokens_due.size();
        o_checked    = checked_cnt;
    end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench top: drives byte requests into the tokenizer and gives the verdict.
`default_nettype none

module tb_top;
    import csft_pkg::*;

    // Run guard: far above the slowest legal run (a few hundred requests,
    // each up to four tokens under heavy stalls).
    localparam int CYCLE_LIMIT  = 100_000;
    // Settle time after the token queue empties: pipeline depth plus margin.
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 80;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_byte_value   = 8'd0;
    logic        i_end_of_input = 1'b0;
    logic        i_read_error   = 1'b0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_kind;
    logic [7:0]  o_field_byte;
    logic [31:0] o_line_number;
    logic [15:0] o_field_count;
    logic        o_last;

    int fail_count;
    int pending;
    int checked;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int requests_sent  = 0;
    int cycles         = 0;

    comment_strip_field_tokenizer_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_byte_value   (i_byte_value),
        .i_end_of_input (i_end_of_input),
        .i_read_error   (i_read_error),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_field_byte   (o_field_byte),
        .o_line_number  (o_line_number),
        .o_field_count  (o_field_count),
        .o_last         (o_last)
    );

    csft_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_byte_value   (i_byte_value),
        .i_end_of_input (i_end_of_input),
        .i_read_error   (i_read_error),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_kind         (o_kind),
        .i_field_byte   (o_field_byte),
        .i_line_number  (o_line_number),
        .i_field_count  (o_field_count),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always #10 i_clk = ~i_clk;

    // Receiver: stall at random with the current phase's probability.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard stop if the run hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d tokens still pending", cycles, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    // Send one request. Valid stays high from the previous request unless an
    // idle gap is drawn, so back-to-back requests never lower and raise valid
    // in the same step.
    task automatic send_req(input logic [7:0] b, input logic eoi, input logic rerr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_byte_value   <= b;
        i_end_of_input <= eoi;
        i_read_error   <= rerr;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_req(b, 1'b0, 1'b0);
    endtask

    // End-of-input mark; the byte lane carries random garbage that must be ignored.
    task automatic send_eoi();
        send_req(8'($urandom_range(255)), 1'b1, 1'b0);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Plain field character: letters mostly, bytes with the top bit set sometimes.
    function automatic logic [7:0] word_char();
        if ($urandom_range(3) == 0)
            return 8'($urandom_range(8'h80, 8'hFF));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_FF;
            3:       return CH_VT;
            default: return CH_CR;
        endcase
    endfunction

    // Comment body: any non-NUL byte, so newlines, stars and slashes land inside too.
    task automatic send_junk();
        int n;
        n = $urandom_range(3);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(1, 255)));
    endtask

    // One well-formed line: words, '=', blanks and every comment form, closed
    // by a newline or now and then by an end-of-input mark.
    task automatic send_line();
        int ntok;
        int len;
        ntok = $urandom_range(5);
        for (int k = 0; k < ntok; k++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    len = $urandom_range(1, 5);
                    for (int j = 0; j < len; j++)
                        send_byte(word_char());
                end
                4: send_byte(CH_EQUALS);
                5: send_byte(blank_char());
                6: begin
                    send_byte(CH_HASH);
                    send_junk();
                end
                7: begin
                    send_text("//");
                    send_junk();
                end
                8: begin
                    // leave the block open now and then so it spans lines
                    send_text("/*");
                    send_junk();
                    if ($urandom_range(2) != 0)
                        send_text("*/");
                end
                default: send_byte(CH_SLASH);
            endcase
        end
        if ($urandom_range(9) == 0)
            send_eoi();
        else
            send_byte(CH_LF);
    endtask

    // Mostly well-formed lines; the rest is raw noise and stray end marks.
    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
        int start;
        int roll;
        int len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = requests_sent;
        while (requests_sent - start < n_items) begin
            roll = $urandom_range(99);
            if (roll < 15) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom_range(1, 255)));
            end else if (roll < 20) begin
                send_eoi();
            end else begin
                send_line();
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, every blank, '=' as its own field.
        send_byte(8'hFF);
        send_byte(CH_SPACE);
        send_byte(8'h01);
        send_byte(CH_TAB);
        send_text("x=y");
        send_byte(CH_FF);
        send_byte(CH_VT);
        send_byte(CH_CR);
        send_byte(CH_LF);
        // Slash that starts no comment becomes a field byte.
        send_text("/z");
        // Block comment spans the newline, closes mid-line; then a line comment.
        send_text("p/*q");
        send_byte(CH_LF);
        send_text("*/r//");
        send_byte(CH_LF);
        // End of input with a held slash: flush it, close the line, then the mark.
        send_text("w/");
        send_req(8'h00, 1'b1, 1'b0);
        // End of input on an empty line, then an empty line.
        send_req(8'hFF, 1'b1, 1'b0);
        send_byte(CH_LF);
        // Comment-only line closed by end of input: counted, not reported.
        send_byte(CH_HASH);
        send_eoi();

        // Random traffic under the four pacing phases.
        run_phase(0, 0, PHASE_ITEMS);
        run_phase(53, 0, PHASE_ITEMS);
        run_phase(0, 53, PHASE_ITEMS);
        run_phase(32, 32, PHASE_ITEMS);

        // Sticky failure tail: trip it one of three ways, then confirm it holds.
        case ($urandom_range(2))
            0:       send_byte(CH_NUL);
            1:       send_req(8'($urandom_range(255)), 1'b0, 1'b1);
            default: send_req(8'($urandom_range(255)), 1'b1, 1'b1);
        endcase
        send_text("a=");
        send_eoi();
        send_req(8'h00, 1'b0, 1'b1);
        send_byte(CH_LF);

        i_in_valid <= 1'b0;

        // Sample the checker away from the clock edge so its update has settled.
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d byte requests and %0d checked tokens in four pacing phases,",
                 requests_sent, checked);
        $display("with every blank, every comment form and a sticky failure tail.");
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
